// File: rtl/grouped_trip_statistics_accumulator_defines.svh
// Assertion helpers for the statistics accumulator checker.
`ifndef GROUPED_TRIP_STATISTICS_ACCUMULATOR_DEFINES_SVH
`define GROUPED_TRIP_STATISTICS_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GTSA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GTSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/gtsa_pkg.sv
`timescale 1ns / 1ps
package gtsa_pkg;

  localparam int GROUP_SLOTS         = 256;
  localparam int SPEED_FRACTION_BITS = 8;
  localparam int MEASURES            = 4;

  localparam int GROUP_W   = 8;
  localparam int GROUP_AW  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int STAT_AW   = GROUP_AW + 2;
  localparam int STAT_DEPTH = GROUP_SLOTS * MEASURES;

  localparam int VAL_W  = 24;
  localparam int SUM_W  = 63;
  localparam int CNT_W  = 32;
  localparam int WGT_W  = 16;
  localparam int TURN_W = 10;

  localparam int NUM_W      = VAL_W + SPEED_FRACTION_BITS;
  localparam int DIV_STEP_W = $clog2(NUM_W + 1);

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_IGNORED    = 2'd1,
    ST_READ_OK    = 2'd2,
    ST_READ_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_DIV,
    S_RD,
    S_MUL1,
    S_MUL2,
    S_WR,
    S_RDOUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0] min;
    logic [VAL_W-1:0] max;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sumsq;
  } stat_entry_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [STAT_AW-1:0] addr;
    stat_entry_t        wdata;
  } stat_req_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;
    logic [VAL_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/gtsa_divider.sv
`timescale 1ns / 1ps
module gtsa_divider
  import gtsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [NUM_W-1:0] SAT = NUM_W'(VAL_MAX);

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic [NUM_W-1:0]      num_q;
  logic [NUM_W-1:0]      quot_q;
  logic [VAL_W-1:0]      rem_q;
  logic [VAL_W-1:0]      dvs_q;
  logic [VAL_W:0]        rem_sh;
  logic                  fits;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        step_q <= '0;
        if (req_i.divisor == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == DIV_STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= req_i.dividend;
      dvs_q  <= req_i.divisor;
      rem_q  <= '0;
      quot_q <= (req_i.divisor == '0) ? req_i.dividend : '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      quot_q <= {quot_q[NUM_W-2:0], fits};
      rem_q  <= fits ? VAL_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[VAL_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (quot_q > SAT) ? VAL_MAX : quot_q[VAL_W-1:0];

endmodule

// File: rtl/gtsa_count_store.sv
`timescale 1ns / 1ps
module gtsa_count_store
  import gtsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [GROUP_AW-1:0] rd_addr_i,
  output logic [CNT_W-1:0]    rd_data_o,
  input  logic                wr_en_i,
  input  logic [GROUP_AW-1:0] wr_addr_i,
  input  logic [CNT_W-1:0]    wr_data_i
);

  logic [CNT_W-1:0]       mem [GROUP_SLOTS];
  logic [GROUP_SLOTS-1:0] valid_q;
  logic [CNT_W-1:0]       rd_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // an entry never written reads as an empty group
  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// File: rtl/gtsa_stat_store.sv
`timescale 1ns / 1ps
module gtsa_stat_store
  import gtsa_pkg::*;
(
  input  logic        clk_i,
  input  stat_req_t   req_i,
  output stat_entry_t rd_data_o
);

  stat_entry_t mem [STAT_DEPTH];
  stat_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/grouped_trip_statistics_accumulator.sv
`timescale 1ns / 1ps
// Grouped trip statistics accumulator. Pulse start_i while busy_o is low to
// hand in one item; exactly one result follows, shown for a single cycle with
// done_o high, and the receiver cannot stall it, so capture it then. busy_o
// stays high from acceptance up to and including the done_o cycle. A read of a
// stored group passes through S_CNT, S_RDOUT and S_DONE, an ignored add through
// S_CNT and S_DONE; an add with non-zero weight first runs a bit-serial speed
// divider, which gives one quotient bit per cycle and skips the division when
// trip_time is zero, then each of the four measures goes through a read, two
// multiply stages and a write-back on the single port of the statistics memory.
// Statistics of a group are only valid once its trip count is non-zero; the
// count table is cleared by reset.
module grouped_trip_statistics_accumulator
  import gtsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               opcode_i,
  input  logic [GROUP_W-1:0] group_index_i,
  input  logic [1:0]         measure_select_i,
  input  logic [VAL_W-1:0]   trip_distance_i,
  input  logic [VAL_W-1:0]   trip_time_i,
  input  logic [TURN_W-1:0]  trip_turns_i,
  input  logic [WGT_W-1:0]   trip_weight_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [CNT_W-1:0]   group_trips_o,
  output logic [VAL_W-1:0]   measure_min_o,
  output logic [VAL_W-1:0]   measure_max_o,
  output logic [SUM_W-1:0]   measure_sum_o,
  output logic [SUM_W-1:0]   measure_sum_squares_o
);

  state_e state_q, state_d;

  logic               op_q;
  logic [GROUP_W-1:0] grp_q;
  logic [1:0]         sel_q;
  logic [VAL_W-1:0]   dist_q;
  logic [VAL_W-1:0]   time_q;
  logic [TURN_W-1:0]  turns_q;
  logic [WGT_W-1:0]   wgt_q;
  logic [VAL_W-1:0]   speed_q;
  logic [1:0]         meas_q;
  logic [VAL_W+WGT_W-1:0] lin_q;
  logic [2*VAL_W-1:0]     vv_q;
  logic [2*VAL_W+WGT_W-1:0] sq_q;

  status_e          status_q;
  logic [CNT_W-1:0] trips_q;
  logic [VAL_W-1:0] min_q;
  logic [VAL_W-1:0] max_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sumsq_q;

  logic [CNT_W-1:0] cnt_rd;
  logic             cnt_we;
  logic [CNT_W:0]   cnt_sum;
  logic [CNT_W-1:0] cnt_new;
  logic             in_range;
  logic             first;
  logic [VAL_W-1:0] v;
  stat_req_t        stat_req;
  stat_entry_t      stat_rd;
  stat_entry_t      stat_new;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [SUM_W+1:0] lin_acc;
  logic [SUM_W+1:0] sq_acc;
  logic [SUM_W-1:0] base_sum;
  logic [SUM_W-1:0] base_sumsq;

  assign in_range = 32'(grp_q) < 32'(GROUP_SLOTS);
  assign first    = (cnt_rd == '0);
  assign cnt_sum  = {1'b0, cnt_rd} + (CNT_W + 1)'(wgt_q);
  assign cnt_new  = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];

  always_comb begin
    case (meas_q)
      2'd0:    v = dist_q;
      2'd1:    v = time_q;
      2'd2:    v = speed_q;
      default: v = VAL_W'(turns_q);
    endcase
  end

  // fold one measure into its stored entry, saturating the sums
  always_comb begin
    base_sum   = first ? '0 : stat_rd.sum;
    base_sumsq = first ? '0 : stat_rd.sumsq;
    lin_acc    = (SUM_W + 2)'(base_sum) + (SUM_W + 2)'(lin_q);
    sq_acc     = (SUM_W + 2)'(base_sumsq) + (SUM_W + 2)'(sq_q);
    stat_new.sum   = (lin_acc > (SUM_W + 2)'(SUM_MAX)) ? SUM_MAX : lin_acc[SUM_W-1:0];
    stat_new.sumsq = (sq_acc > (SUM_W + 2)'(SUM_MAX)) ? SUM_MAX : sq_acc[SUM_W-1:0];
    stat_new.min   = (first || v < stat_rd.min) ? v : stat_rd.min;
    stat_new.max   = (first || v > stat_rd.max) ? v : stat_rd.max;
  end

  gtsa_count_store u_count (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i ((state_q == S_IDLE) ? GROUP_AW'(group_index_i) : GROUP_AW'(grp_q)),
    .rd_data_o (cnt_rd),
    .wr_en_i   (cnt_we),
    .wr_addr_i (GROUP_AW'(grp_q)),
    .wr_data_i (cnt_new)
  );

  gtsa_stat_store u_stat (
    .clk_i     (clk_i),
    .req_i     (stat_req),
    .rd_data_o (stat_rd)
  );

  gtsa_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_CNT;
      S_CNT: begin
        if (op_q == OP_READ) begin
          state_d = (!in_range || first) ? S_DONE : S_RDOUT;
        end else begin
          state_d = (!in_range || wgt_q == '0) ? S_DONE : S_DIV;
        end
      end
      S_DIV:   if (div_rsp.done) state_d = S_RD;
      S_RD:    state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_WR;
      S_WR:    state_d = (meas_q == 2'd3) ? S_DONE : S_RD;
      S_RDOUT: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    stat_req.rd_en    = 1'b0;
    stat_req.wr_en    = 1'b0;
    stat_req.addr     = {GROUP_AW'(grp_q), meas_q};
    stat_req.wdata    = stat_new;
    div_req.start     = 1'b0;
    div_req.dividend  = NUM_W'(dist_q) << SPEED_FRACTION_BITS;
    div_req.divisor   = time_q;
    cnt_we            = 1'b0;
    done_o            = 1'b0;
    case (state_q)
      S_CNT: begin
        if (op_q == OP_READ) begin
          stat_req.rd_en = in_range && !first;
          stat_req.addr  = {GROUP_AW'(grp_q), sel_q};
        end else begin
          div_req.start = in_range && wgt_q != '0;
        end
      end
      S_RD:    stat_req.rd_en = 1'b1;
      S_WR: begin
        stat_req.wr_en = 1'b1;
        cnt_we         = (meas_q == 2'd3);
      end
      S_DONE:  done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_q    <= opcode_i;
          grp_q   <= group_index_i;
          sel_q   <= measure_select_i;
          dist_q  <= trip_distance_i;
          time_q  <= trip_time_i;
          turns_q <= trip_turns_i;
          wgt_q   <= trip_weight_i;
        end
      end
      S_CNT: begin
        meas_q  <= 2'd0;
        min_q   <= '0;
        max_q   <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
        if (op_q == OP_READ) begin
          status_q <= (!in_range || first) ? ST_READ_EMPTY : ST_READ_OK;
          trips_q  <= (!in_range) ? '0 : cnt_rd;
        end else begin
          status_q <= ST_IGNORED;
          trips_q  <= (!in_range) ? '0 : cnt_rd;
        end
      end
      S_DIV:  if (div_rsp.done) speed_q <= div_rsp.quotient;
      S_MUL1: begin
        lin_q <= (VAL_W + WGT_W)'(v) * (VAL_W + WGT_W)'(wgt_q);
        vv_q  <= (2 * VAL_W)'(v) * (2 * VAL_W)'(v);
      end
      S_MUL2: sq_q <= (2 * VAL_W + WGT_W)'(vv_q) * (2 * VAL_W + WGT_W)'(wgt_q);
      S_WR: begin
        meas_q   <= meas_q + 2'd1;
        status_q <= ST_ADDED;
        trips_q  <= cnt_new;
      end
      S_RDOUT: begin
        min_q   <= stat_rd.min;
        max_q   <= stat_rd.max;
        sum_q   <= stat_rd.sum;
        sumsq_q <= stat_rd.sumsq;
      end
      default: ;
    endcase
  end

  assign busy_o                = (state_q != S_IDLE);
  assign status_o              = status_q;
  assign group_trips_o         = trips_q;
  assign measure_min_o         = min_q;
  assign measure_max_o         = max_q;
  assign measure_sum_o         = sum_q;
  assign measure_sum_squares_o = sumsq_q;

endmodule

// File: rtl/gtsa_checker.sv
`timescale 1ns / 1ps
`include "grouped_trip_statistics_accumulator_defines.svh"
module gtsa_checker
  import gtsa_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic [VAL_W-1:0]   measure_min_o,
  input logic [VAL_W-1:0]   measure_max_o,
  input logic [SUM_W-1:0]   measure_sum_o,
  input logic [SUM_W-1:0]   measure_sum_squares_o
);

  `GTSA_ASSERT_NOW(a_done_while_busy, done_o, busy_o, "result strobe outside busy window")
  `GTSA_ASSERT_NEXT(a_accept_sets_busy, start_i && !busy_o, busy_o, "accepted item not busy")
  `GTSA_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy_o, "result strobe not one cycle")
  `GTSA_ASSERT_NOW(a_add_zero_stats,
    done_o && (status_o == ST_ADDED || status_o == ST_IGNORED),
    measure_min_o == '0 && measure_max_o == '0 && measure_sum_o == '0 &&
    measure_sum_squares_o == '0, "add result carries statistics")

endmodule

bind grouped_trip_statistics_accumulator gtsa_checker u_gtsa_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import gtsa_pkg::*;

  typedef struct packed {
    opcode_e             op;
    logic [GROUP_W-1:0]  grp;
    logic [1:0]          sel;
    logic [VAL_W-1:0]    distance;
    logic [VAL_W-1:0]    tim;
    logic [TURN_W-1:0]   turns;
    logic [WGT_W-1:0]    weight;
  } trip_item_t;

  typedef struct packed {
    status_e             status;
    logic [CNT_W-1:0]    trips;
    logic [VAL_W-1:0]    vmin;
    logic [VAL_W-1:0]    vmax;
    logic [SUM_W-1:0]    vsum;
    logic [SUM_W-1:0]    vsumsq;
  } stats_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               opcode_i = 1'b0;
  logic [GROUP_W-1:0] group_index_i = '0;
  logic [1:0]         measure_select_i = '0;
  logic [VAL_W-1:0]   trip_distance_i = '0;
  logic [VAL_W-1:0]   trip_time_i = '0;
  logic [TURN_W-1:0]  trip_turns_i = '0;
  logic [WGT_W-1:0]   trip_weight_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [CNT_W-1:0]   group_trips_o;
  logic [VAL_W-1:0]   measure_min_o;
  logic [VAL_W-1:0]   measure_max_o;
  logic [SUM_W-1:0]   measure_sum_o;
  logic [SUM_W-1:0]   measure_sum_squares_o;

  grouped_trip_statistics_accumulator dut (.*);

  // Shadow copy of the group table
  logic [CNT_W-1:0] group_count [GROUP_SLOTS];
  logic [VAL_W-1:0] shadow_min [STAT_DEPTH];
  logic [VAL_W-1:0] shadow_max [STAT_DEPTH];
  logic [SUM_W-1:0] shadow_sum [STAT_DEPTH];
  logic [SUM_W-1:0] shadow_sumsq [STAT_DEPTH];

  stats_result_t pending_stats [$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [63:0] inc);
    if (inc >= {1'b0, SUM_MAX} || {1'b0, SUM_MAX - acc} < inc) return SUM_MAX;
    return acc + inc[SUM_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] trip_speed(logic [VAL_W-1:0] d, logic [VAL_W-1:0] t);
    logic [63:0] num;
    logic [63:0] q;
    num = {40'd0, d} << SPEED_FRACTION_BITS;
    q = (t != 0) ? num / t : num;
    return (q > VAL_MAX) ? VAL_MAX : q[VAL_W-1:0];
  endfunction

  function automatic stats_result_t fold_trip(trip_item_t it);
    stats_result_t r;
    logic [63:0] vals [MEASURES];
    logic [63:0] cnt;
    logic [63:0] v;
    int idx;
    bit first;
    r = '0;
    cnt = group_count[it.grp];
    if (it.op == OP_ADD) begin
      if (it.weight == 0) begin
        r.status = ST_IGNORED;
        r.trips = cnt[CNT_W-1:0];
        return r;
      end
      vals[0] = it.distance;
      vals[1] = it.tim;
      vals[2] = trip_speed(it.distance, it.tim);
      vals[3] = it.turns;
      first = (cnt == 0);
      for (int m = 0; m < MEASURES; m++) begin
        idx = it.grp * MEASURES + m;
        v = vals[m];
        if (first) begin
          shadow_min[idx] = v[VAL_W-1:0];
          shadow_max[idx] = v[VAL_W-1:0];
          shadow_sum[idx] = sat_sum('0, v * it.weight);
          shadow_sumsq[idx] = sat_sum('0, v * v * it.weight);
        end else begin
          if (v < shadow_min[idx]) shadow_min[idx] = v[VAL_W-1:0];
          if (v > shadow_max[idx]) shadow_max[idx] = v[VAL_W-1:0];
          shadow_sum[idx] = sat_sum(shadow_sum[idx], v * it.weight);
          shadow_sumsq[idx] = sat_sum(shadow_sumsq[idx], v * v * it.weight);
        end
      end
      cnt = cnt + it.weight;
      if (cnt > CNT_MAX) cnt = CNT_MAX;
      group_count[it.grp] = cnt[CNT_W-1:0];
      r.status = ST_ADDED;
      r.trips = cnt[CNT_W-1:0];
      return r;
    end
    if (cnt == 0) begin
      r.status = ST_READ_EMPTY;
      return r;
    end
    idx = it.grp * MEASURES + it.sel;
    r.status = ST_READ_OK;
    r.trips = cnt[CNT_W-1:0];
    r.vmin = shadow_min[idx];
    r.vmax = shadow_max[idx];
    r.vsum = shadow_sum[idx];
    r.vsumsq = shadow_sumsq[idx];
    return r;
  endfunction

  // Hold start high until the block takes the item; leave it high afterwards
  task automatic send_item(trip_item_t it);
    opcode_i <= it.op;
    group_index_i <= it.grp;
    measure_select_i <= it.sel;
    trip_distance_i <= it.distance;
    trip_time_i <= it.tim;
    trip_turns_i <= it.turns;
    trip_weight_i <= it.weight;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_stats.insert(pending_stats.size(), fold_trip(it));
  endtask

  task automatic idle_for(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_stats.size() != 0 || busy_o);
  endtask

  always @(posedge clk_i) begin
    stats_result_t got;
    stats_result_t want;
    if (rst_ni && done_o) begin
      got = {status_e'(status_o), group_trips_o, measure_min_o, measure_max_o,
             measure_sum_o, measure_sum_squares_o};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic trip_item_t make_item(opcode_e op, int grp, int sel, int d, int t,
                                           int tu, int w);
    trip_item_t it;
    it.op = op; it.grp = GROUP_W'(grp); it.sel = 2'(sel); it.distance = VAL_W'(d);
    it.tim = VAL_W'(t); it.turns = TURN_W'(tu); it.weight = WGT_W'(w);
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return VAL_MAX;
      2: return VAL_W'($urandom_range(0, 255));
      default: return VAL_W'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ADD, 0, 3, 5, 5, 5, 0));
    // first add with time zero: speed saturates, distance and speed square sums saturate
    send_item(make_item(OP_ADD, 0, 1, VAL_MAX, 0, 1023, 16'hFFFF));
    for (int s = 0; s < MEASURES; s++) send_item(make_item(OP_READ, 0, s, 0, 0, 0, 0));
    send_item(make_item(OP_ADD, 0, 0, 0, 1, 0, 1));
    send_item(make_item(OP_ADD, 0, 2, 1000, VAL_MAX, 7, 3));
    for (int s = 0; s < MEASURES; s++) send_item(make_item(OP_READ, 0, s, 0, 0, 0, 0));
    send_item(make_item(OP_ADD, 255, 0, 300, 7, 0, 2));
    send_item(make_item(OP_ADD, 255, 0, 1, 0, 1023, 1));
    send_item(make_item(OP_ADD, 255, 0, 9, 9, 9, 0));
    idle_for(3);
    for (int s = 0; s < MEASURES; s++) send_item(make_item(OP_READ, 255, s, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 128, 2, VAL_MAX, VAL_MAX, 1023, 16'hFFFF));
    wait_drained();
  endtask

  task automatic test_random(int n);
    trip_item_t it;
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      it.op = ($urandom_range(0, 9) < 6) ? OP_ADD : OP_READ;
      it.grp = GROUP_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 7));
      it.sel = 2'($urandom_range(0, 3));
      it.distance = pick_value();
      it.tim = pick_value();
      it.turns = TURN_W'($urandom_range(0, 1023));
      case ($urandom_range(0, 9))
        0: it.weight = 0;
        1: it.weight = 16'hFFFF;
        2, 3: it.weight = WGT_W'($urandom());
        default: it.weight = WGT_W'($urandom_range(1, 20));
      endcase
      send_item(it);
      if (i == n / 2) wait_drained();
      else if (burst == 0) begin
        burst = $urandom_range(1, 12);
        idle_for($urandom_range(1, 60));
      end else burst--;
    end
    wait_drained();
  endtask

  initial begin
    for (int g = 0; g < GROUP_SLOTS; g++) group_count[g] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/gtsa_pkg.sv
rtl/gtsa_divider.sv
rtl/gtsa_count_store.sv
rtl/gtsa_stat_store.sv
rtl/grouped_trip_statistics_accumulator.sv
rtl/gtsa_checker.sv
bench/tb_top.sv
